[rtl/motor_command_packet_receiver_defines.svh]
// Assertion macros for the motor command packet receiver.
// Included by the top level; no other dependencies.
`ifndef MOTOR_COMMAND_PACKET_RECEIVER_DEFINES_SVH
`define MOTOR_COMMAND_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication under a synchronous active-high reset
`define MCPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under a synchronous active-high reset
`define MCPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mcpr_pkg.sv]
// Shared constants, codes and types for the motor command packet receiver.
// No dependencies.
package mcpr_pkg;

   localparam int PACKET_BYTES = 10;
   localparam int CHANNELS     = 4;

   localparam int POS_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
   localparam logic [1:0]       LAST_CH  = 2'(CHANNELS - 1);

   localparam logic [7:0]  CRC_POLY      = 8'h91;
   localparam logic [15:0] COMPARE_RESET = 16'd499;

   localparam logic [7:0]  HEADER_RESET  = 8'd51;
   localparam logic [15:0] MIN_RESET     = 16'd500;
   localparam logic [15:0] SCALE_RESET   = 16'd500;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd3;

   // Event codes
   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_ACCEPT     = 3'd1;
   localparam logic [2:0] EV_BAD_CRC    = 3'd2;
   localparam logic [2:0] EV_BAD_HEADER = 3'd3;
   localparam logic [2:0] EV_TIMEOUT    = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_CRC        = 5'b00010,
      ST_CONV_START = 5'b00100,
      ST_CONV_WAIT  = 5'b01000,
      ST_DONE       = 5'b10000
   } state_type;

   // Request into the conversion unit
   typedef struct packed {
      logic        start;
      logic [15:0] value;
      logic [15:0] min_pulse;
      logic [15:0] full_scale;
   } conv_req_type;

   // Status back from the conversion unit
   typedef struct packed {
      logic        done;
      logic [15:0] result;
   } conv_rsp_type;

endpackage

[rtl/motor_command_packet_receiver.sv]
// Motor command packet receiver: frames 10-byte CRC-8 checked packets,
// converts four channel values into PWM compares, and runs a failsafe timeout.
// Depends on mcpr_pkg, mcpr_crc, mcpr_conv and the assertion macro header.
//
// Input channel (req_): one transfer carries either a received byte
// (req_func = 0) or a timeout tick (req_func = 1). Result channel (rsp_):
// exactly one transfer per input item, with the four compares as they stand
// after the item and an event code. Configuration (csr_) is a write-only port;
// the user writes it only while the block is idle; the block does no check.
// The block works on one item at a time and holds req_stall high meanwhile.
// Work done for each item before its result:
//   tick                      no further work
//   byte inside a packet      bit-serial CRC, one round per cycle
//   last byte, rejected       no further work
//   last byte, accepted       multiply, 32-step divide and saturate in the
//                             shared conversion unit, once per channel
// The result sits in an output register: the next item is taken while it
// waits on rsp_stall; a further result waits in the sequencer until taken.
// Reset clears framing, the idle counter and the output, sets all compares
// to 499 and restores register defaults.
`include "motor_command_packet_receiver_defines.svh"

module motor_command_packet_receiver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_compare_one,
   output logic [15:0]                       rsp_compare_two,
   output logic [15:0]                       rsp_compare_three,
   output logic [15:0]                       rsp_compare_four,
   output logic [2:0]                        rsp_event_code,
   input  logic                              csr_write_en,
   input  logic [mcpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mcpr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration
   logic [7:0]  header_ff;
   logic [15:0] min_pulse_ff;
   logic [15:0] full_scale_ff;
   logic [15:0] timeout_ff;

   // Sequencer and framing state
   mcpr_pkg::state_type             state_ff,   state_in;
   logic [mcpr_pkg::POS_W-1:0]      pos_ff,     pos_in;
   logic [7:0]                      crc_ff,     crc_in;
   logic                            hmatch_ff,  hmatch_in;
   logic [7:0]                      low_ff,     low_in;
   logic [15:0]                     idle_ff,    idle_in;
   logic [1:0]                      ch_ff,      ch_in;
   logic [2:0]                      ev_ff,      ev_in;
   logic [15:0]                     pending_ff [4];
   logic [15:0]                     active_ff  [4];
   logic [15:0]                     active_in  [4];

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] out_ff [4];
   logic [2:0]  out_ev_ff;

   logic        req_take;
   logic        rsp_take;
   logic        out_load;
   logic        crc_start;
   logic [7:0]  crc_seed;
   logic        crc_done;
   logic [7:0]  crc_out;
   logic [16:0] tick_next;
   logic [2:0]  wr_ch;
   logic        pend_we;
   mcpr_pkg::conv_req_type conv_req;
   mcpr_pkg::conv_rsp_type conv_rsp;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != mcpr_pkg::ST_IDLE);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_load  = (state_ff == mcpr_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign tick_next = {1'b0, idle_ff} + 17'd1;
   assign crc_seed  = ((pos_ff == '0) ? 8'd0 : crc_ff) ^ req_data_byte;
   assign crc_start = req_take && !req_func && (pos_ff != mcpr_pkg::LAST_POS);

   // Even positions 2..8 close a channel value
   assign wr_ch   = 3'(pos_ff[3:1]) - 3'd1;
   assign pend_we = crc_start && !pos_ff[0] && (pos_ff != '0)
                    && (32'(wr_ch) < mcpr_pkg::CHANNELS);

   mcpr_crc u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_start),
      .seed  (crc_seed),
      .done  (crc_done),
      .crc   (crc_out)
   );

   always_comb begin
      conv_req.start      = (state_ff == mcpr_pkg::ST_CONV_START);
      conv_req.value      = pending_ff[ch_ff];
      conv_req.min_pulse  = min_pulse_ff;
      conv_req.full_scale = full_scale_ff;
   end

   mcpr_conv u_conv (
      .clock (clock),
      .reset (reset),
      .req   (conv_req),
      .rsp   (conv_rsp)
   );

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      hmatch_in = hmatch_ff;
      low_in    = low_ff;
      idle_in   = idle_ff;
      ch_in     = ch_ff;
      ev_in     = ev_ff;
      for (int i = 0; i < 4; i++) begin
         active_in[i] = active_ff[i];
      end

      case (state_ff)
         mcpr_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_func) begin
                  state_in = mcpr_pkg::ST_DONE;
                  if (tick_next >= {1'b0, timeout_ff}) begin
                     // Failsafe: restart framing and force compares
                     idle_in = 16'd0;
                     pos_in  = '0;
                     ev_in   = mcpr_pkg::EV_TIMEOUT;
                     for (int i = 0; i < mcpr_pkg::CHANNELS; i++) begin
                        active_in[i] = min_pulse_ff;
                     end
                  end else begin
                     idle_in = tick_next[15:0];
                     ev_in   = mcpr_pkg::EV_NONE;
                  end
               end else if (pos_ff != mcpr_pkg::LAST_POS) begin
                  if (pos_ff == '0) begin
                     hmatch_in = (req_data_byte == header_ff);
                  end
                  if (pos_ff[0]) begin
                     low_in = req_data_byte;
                  end
                  pos_in   = pos_ff + 1'b1;
                  ev_in    = mcpr_pkg::EV_NONE;
                  state_in = mcpr_pkg::ST_CRC;
               end else begin
                  pos_in = '0;
                  if (!hmatch_ff) begin
                     ev_in    = mcpr_pkg::EV_BAD_HEADER;
                     state_in = mcpr_pkg::ST_DONE;
                  end else if (req_data_byte != crc_ff) begin
                     ev_in    = mcpr_pkg::EV_BAD_CRC;
                     state_in = mcpr_pkg::ST_DONE;
                  end else begin
                     ch_in    = 2'd0;
                     state_in = mcpr_pkg::ST_CONV_START;
                  end
               end
            end
         end
         mcpr_pkg::ST_CRC: begin
            if (crc_done) begin
               crc_in   = crc_out;
               state_in = mcpr_pkg::ST_DONE;
            end
         end
         mcpr_pkg::ST_CONV_START: begin
            state_in = mcpr_pkg::ST_CONV_WAIT;
         end
         mcpr_pkg::ST_CONV_WAIT: begin
            if (conv_rsp.done) begin
               active_in[ch_ff] = conv_rsp.result;
               if (ch_ff == mcpr_pkg::LAST_CH) begin
                  idle_in  = 16'd0;
                  ev_in    = mcpr_pkg::EV_ACCEPT;
                  state_in = mcpr_pkg::ST_DONE;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = mcpr_pkg::ST_CONV_START;
               end
            end
         end
         mcpr_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = mcpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcpr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff     <= mcpr_pkg::HEADER_RESET;
         min_pulse_ff  <= mcpr_pkg::MIN_RESET;
         full_scale_ff <= mcpr_pkg::SCALE_RESET;
         timeout_ff    <= mcpr_pkg::TIMEOUT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            mcpr_pkg::CSR_HEADER:  header_ff     <= csr_wdata[7:0];
            mcpr_pkg::CSR_MIN:     min_pulse_ff  <= csr_wdata;
            mcpr_pkg::CSR_SCALE:   full_scale_ff <= csr_wdata;
            mcpr_pkg::CSR_TIMEOUT: timeout_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcpr_pkg::ST_IDLE;
         pos_ff       <= '0;
         crc_ff       <= 8'd0;
         hmatch_ff    <= 1'b0;
         low_ff       <= 8'd0;
         idle_ff      <= 16'd0;
         ch_ff        <= 2'd0;
         ev_ff        <= mcpr_pkg::EV_NONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            active_ff[i] <= mcpr_pkg::COMPARE_RESET;
         end
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         hmatch_ff    <= hmatch_in;
         low_ff       <= low_in;
         idle_ff      <= idle_in;
         ch_ff        <= ch_in;
         ev_ff        <= ev_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            active_ff[i] <= active_in[i];
         end
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pending_ff[wr_ch[1:0]] <= {req_data_byte, low_ff};
      end
      if (out_load) begin
         for (int i = 0; i < 4; i++) begin
            out_ff[i] <= active_ff[i];
         end
         out_ev_ff <= ev_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_one   = out_ff[0];
   assign rsp_compare_two   = out_ff[1];
   assign rsp_compare_three = out_ff[2];
   assign rsp_compare_four  = out_ff[3];
   assign rsp_event_code    = out_ev_ff;

   `MCPR_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, req_stall, "not busy after input transfer")
   `MCPR_ASSERT_SAME(a_crc_done_in_crc, clock, reset, crc_done, state_ff == mcpr_pkg::ST_CRC, "CRC finished outside CRC state")
   `MCPR_ASSERT_SAME(a_conv_done_in_wait, clock, reset, conv_rsp.done, state_ff == mcpr_pkg::ST_CONV_WAIT, "conversion finished outside wait state")

endmodule

[rtl/mcpr_crc.sv]
// Bit-serial CRC-8 unit: one shift round per cycle, eight rounds per byte.
// Depends on mcpr_pkg.
module mcpr_crc (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] seed,
   output logic       done,
   output logic [7:0] crc
);

   logic       busy_ff,  busy_in;
   logic       done_ff,  done_in;
   logic [2:0] cnt_ff,   cnt_in;
   logic [7:0] crc_ff,   crc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      crc_in  = crc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         crc_in  = seed;
      end else if (busy_ff) begin
         crc_in = crc_ff[0] ? ((crc_ff ^ mcpr_pkg::CRC_POLY) >> 1) : (crc_ff >> 1);
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      crc_ff <= crc_in;
   end

   assign done = done_ff;
   assign crc  = crc_ff;

endmodule

[rtl/mcpr_conv.sv]
// Compare conversion unit: one 16x16 multiply, then a restoring divide
// of one quotient bit per cycle, then add offset and saturate.
// Depends on mcpr_pkg.
module mcpr_conv (
   input  logic                   clock,
   input  logic                   reset,
   input  mcpr_pkg::conv_req_type req,
   output mcpr_pkg::conv_rsp_type rsp
);

   logic        mul_ff,  mul_in;
   logic        run_ff,  run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff,  cnt_in;
   logic [15:0] val_ff,  val_in;
   logic [15:0] off_ff,  off_in;
   logic [15:0] div_ff,  div_in;
   logic [31:0] quo_ff,  quo_in;
   logic [15:0] rem_ff,  rem_in;

   logic [16:0] shifted;
   logic [16:0] diff;
   logic [32:0] sum;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, div_ff};
      sum     = {1'b0, quo_ff} + 33'(off_ff);

      mul_in  = 1'b0;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      off_in  = off_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;

      if (req.start) begin
         mul_in = 1'b1;
         val_in = req.value;
         off_in = req.min_pulse;
         div_in = req.full_scale;
      end
      if (mul_ff) begin
         quo_in = 32'(val_ff) * 32'(off_ff);
         rem_in = 16'd0;
         cnt_in = 5'd0;
         run_in = 1'b1;
      end
      if (run_ff) begin
         // A zero divisor yields an all-ones quotient, which saturates below
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         mul_ff  <= mul_in;
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      off_ff <= off_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = (sum > 33'h0FFFF) ? 16'hFFFF : sum[15:0];

endmodule
